// ===== rtl/b2a_pkg.sv =====
// constants and helper functions for the binary to ascii decimal/hex converter
// no dependencies
`default_nettype none

package b2a_pkg;

    // width of the converted value, 8 to 64
    localparam int VALUE_BITS = 64;
    localparam int VALUE_PORT_BITS = 64;
    localparam int CHAR_BITS = 7;
    localparam int DIGIT_BITS = 4;

    // decimal digits of the largest 64-bit value; also covers every hex nibble
    localparam int NUM_DIGITS = 20;
    localparam int BCD_BITS = NUM_DIGITS * DIGIT_BITS;

    localparam int BIT_CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A = 7'h41;
    localparam logic [DIGIT_BITS-1:0] DEC_BASE = 4'd10;
    localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DABBLE_ADD = 4'd3;

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    typedef logic [BCD_BITS-1:0] bcd_t;

    // add three to every digit of five or more, ahead of the shift
    function automatic bcd_t dabble_fix(input bcd_t bcd);
        bcd_t res;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
                res[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADD;
            end
        end
        return res;
    endfunction

    function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < DEC_BASE) begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end else begin
            c = CHAR_A + CHAR_BITS'(d - DEC_BASE);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/binary_to_ascii_dec_hex_core.sv =====
// binary to ascii converter core: bit-serial double dabble and digit emitter
// depends on b2a_pkg
`default_nettype none

// Converts an unsigned value into its ASCII digits, most significant first,
// one output item per character, uppercase for hex, no leading zeros, and a
// single '0' for zero; m_last marks the final character. A new item is taken
// only while the converter is idle. Decimal items run through a bit-serial
// double-dabble shift (one value bit per cycle into the 20-digit BCD
// register); hex items load their nibbles straight into that register. The
// digit emitter then drops each suppressed leading zero, moves on to sending,
// and sends the characters, held off whenever m_ready stalls the output.
module binary_to_ascii_dec_hex_core (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [b2a_pkg::VALUE_PORT_BITS-1:0]  s_value,
    input  wire                                  s_op,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [b2a_pkg::CHAR_BITS-1:0]        m_digit_char,
    output logic                                 m_last
);
    import b2a_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [VALUE_BITS-1:0]   bin_reg, bin_next;
    bcd_t                    bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]    dig_cnt_reg, dig_cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic [CHAR_BITS-1:0]    m_char_reg, m_char_next;
    logic                    m_last_reg, m_last_next;

    logic [DIGIT_BITS-1:0]   top_digit;
    bcd_t                    bcd_shifted;
    bcd_t                    bcd_fixed;
    logic                    out_free;

    assign top_digit   = bcd_reg[BCD_BITS-1 -: DIGIT_BITS];
    assign bcd_shifted = {bcd_reg[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
    assign bcd_fixed   = dabble_fix(bcd_reg);
    assign out_free    = !m_valid_reg || m_ready;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_char_reg;
    assign m_last       = m_last_reg;

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bin_next     = s_value[VALUE_BITS-1:0];
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    if (s_op == OP_HEX) begin
                        bcd_next   = BCD_BITS'(s_value[VALUE_BITS-1:0]);
                        state_next = ST_SKIP;
                    end else begin
                        bcd_next   = '0;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                // one value bit per cycle into the bcd register
                bcd_next = {bcd_fixed[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (top_digit == '0 && dig_cnt_reg != DIG_CNT_W'(1)) begin
                    bcd_next     = bcd_shifted;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_to_char(top_digit);
                    m_last_next  = (dig_cnt_reg == DIG_CNT_W'(1));
                    bcd_next     = bcd_shifted;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DIG_CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

endmodule

`default_nettype wire
